>>> rtl/skl_pkg.sv
// Shared types and constants of the sorted key table lookup block.
package skl_pkg;

  // Widths fixed by the item and register formats.
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned INDEX_W      = 13;
  localparam int unsigned NSTR_W       = 11;
  localparam int unsigned NLANG_W      = 4;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned S_TDATA_W    = 112;
  localparam int unsigned M_TDATA_W    = 48;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_NUM_STRINGS   = 2'd0;
  localparam logic [1:0] REG_NUM_LANGUAGES = 2'd1;
  localparam logic [1:0] REG_LANGUAGE_SLOT = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WR_KEY = 2'd0,
    ACT_WR_OFF = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_MUL,
    ST_REDUCE,
    ST_OFF_RD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [NSTR_W-1:0]  num_strings;
    logic [NLANG_W-1:0] num_languages;
    logic [SLOT_W-1:0]  language_slot;
  } cfg_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] string_offset;
    logic [POS_W-1:0]    key_position;
  } res_t;

endpackage

>>> rtl/sorted_key_table_lookup_top.sv
// Top level of the sorted key table lookup: ports, registers, memories, output stage.
//
// Requests enter on the s_axis channel. tuser carries the action: key write,
// offset write or lookup. A write gives no result, and the next request is
// taken in the following cycle. A lookup binary-searches the first num_strings
// keys (at most MAX_KEYS) of the key memory and returns one result on m_axis.
// Each probe is one read of the key memory, and a lookup makes at most
// ceil(log2(n+1)) probes, 11 for 1024 keys. A miss then goes to the result;
// a hit goes through multiply, index wrap, offset read and result.
// Only one request is worked on at a time; s_axis_tready is high while the
// sequencer is idle. Results land in an output register, so a new request is
// taken while a finished result still waits on m_axis. If the receiver stalls,
// the next lookup holds its result until that register is free.
// Reset clears the configuration registers to num_strings 0, num_languages 1,
// language_slot 0 and idles the sequencer; the memories are not cleared and
// must be written before they are searched. Configuration goes through an
// APB-style port with registers at byte addresses 0, 4 and 8.
module sorted_key_table_lookup_top import skl_pkg::*; #(
  parameter int unsigned MAX_KEYS  = 1024,
  parameter int unsigned MAX_LANGS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index[12:0], search_key[76:13], offset_value[108:77], zero pad
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // string_offset[31:0], key_position[41:32], zero pad
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // found[0]
  output logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned DEPTH = MAX_KEYS * MAX_LANGS;
  localparam int unsigned KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned OW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t                cfg_q;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  logic                in_acc;
  action_e             action;
  logic [INDEX_W-1:0]  entry_index;
  logic [KEY_W-1:0]    search_key;
  logic [OFFSET_W-1:0] offset_value;

  logic                key_wr_en, off_wr_en;
  logic                key_rd_en, off_rd_en;
  logic [KW-1:0]       key_rd_addr;
  logic [OW-1:0]       off_rd_addr;
  logic [KEY_W-1:0]    key_rd_data;
  logic [OFFSET_W-1:0] off_rd_data;

  logic                idle;
  logic                res_valid, res_take;
  res_t                res;
  logic                out_valid_q;
  res_t                out_q;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_strings   <= '0;
      cfg_q.num_languages <= NLANG_W'(1);
      cfg_q.language_slot <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUM_STRINGS:   cfg_q.num_strings   <= pwdata[NSTR_W-1:0];
        REG_NUM_LANGUAGES: cfg_q.num_languages <= pwdata[NLANG_W-1:0];
        REG_LANGUAGE_SLOT: cfg_q.language_slot <= pwdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NUM_STRINGS:   prdata = CFG_DATA_W'(cfg_q.num_strings);
      REG_NUM_LANGUAGES: prdata = CFG_DATA_W'(cfg_q.num_languages);
      REG_LANGUAGE_SLOT: prdata = CFG_DATA_W'(cfg_q.language_slot);
      default:           prdata = '0;
    endcase
  end

  // Request unpacking.
  assign s_axis_tready = idle;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tuser);
  assign entry_index   = s_axis_tdata[12:0];
  assign search_key    = s_axis_tdata[76:13];
  assign offset_value  = s_axis_tdata[108:77];

  // Writes outside the tables are dropped.
  assign key_wr_en = in_acc && (action == ACT_WR_KEY) &&
                     (32'(entry_index) < 32'(MAX_KEYS));
  assign off_wr_en = in_acc && (action == ACT_WR_OFF) &&
                     (32'(entry_index) < 32'(DEPTH));

  skl_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (key_wr_en),
    .wr_addr_i (KW'(entry_index)),
    .wr_data_i (search_key),
    .rd_en_i   (key_rd_en),
    .rd_addr_i (key_rd_addr),
    .rd_data_o (key_rd_data)
  );

  skl_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (DEPTH)
  ) u_off_ram (
    .clk_i     (clk_i),
    .wr_en_i   (off_wr_en),
    .wr_addr_i (OW'(entry_index)),
    .wr_data_i (offset_value),
    .rd_en_i   (off_rd_en),
    .rd_addr_i (off_rd_addr),
    .rd_data_o (off_rd_data)
  );

  skl_ctrl #(
    .MAX_KEYS  (MAX_KEYS),
    .MAX_LANGS (MAX_LANGS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_acc && (action == ACT_LOOKUP)),
    .key_i         (search_key),
    .cfg_i         (cfg_q),
    .idle_o        (idle),
    .key_rd_en_o   (key_rd_en),
    .key_rd_addr_o (key_rd_addr),
    .key_rd_data_i (key_rd_data),
    .off_rd_en_o   (off_rd_en),
    .off_rd_addr_o (off_rd_addr),
    .off_rd_data_i (off_rd_data),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_take_i    (res_take)
  );

  // Output register: loads when empty or being drained in the same cycle.
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {6'b0, out_q.key_position, out_q.string_offset};

endmodule

>>> rtl/skl_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module skl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/skl_ctrl.sv
// Search sequencer: binary search over the key memory, then the offset read.
module skl_ctrl import skl_pkg::*; #(
  parameter int unsigned MAX_KEYS  = 1024,
  parameter int unsigned MAX_LANGS = 8,
  localparam int unsigned DEPTH = MAX_KEYS * MAX_LANGS,
  localparam int unsigned KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int unsigned OW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [KEY_W-1:0]    key_i,
  input  cfg_t                cfg_i,
  output logic                idle_o,
  output logic                key_rd_en_o,
  output logic [KW-1:0]       key_rd_addr_o,
  input  logic [KEY_W-1:0]    key_rd_data_i,
  output logic                off_rd_en_o,
  output logic [OW-1:0]       off_rd_addr_o,
  input  logic [OFFSET_W-1:0] off_rd_data_i,
  output logic                res_valid_o,
  output res_t                res_o,
  input  logic                res_take_i
);

  // Search bounds hold values up to MAX_KEYS; sums get one more bit.
  localparam int unsigned BW  = KW + 1;
  localparam int unsigned SW  = BW + 1;
  localparam int unsigned OIW = KW + NLANG_W + 1;

  state_e              state_q, state_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [BW-1:0]       first_q, first_d;
  logic [BW-1:0]       end_q, end_d;
  logic [KW-1:0]       mid_q, mid_d;
  logic [OIW-1:0]      oidx_q, oidx_d;
  res_t                res_q, res_d;

  logic [BW-1:0]       n_w;
  logic [NLANG_W-1:0]  nl_w;
  logic [SW-1:0]       mid0_w;
  logic [SW-1:0]       mid_e, first_e, end_e;
  logic [SW-1:0]       next_mid_w;
  logic                cont_w;

  // Effective entry count and languages per key.
  always_comb begin
    if (32'(cfg_i.num_strings) > 32'(MAX_KEYS)) begin
      n_w = BW'(MAX_KEYS);
    end else begin
      n_w = BW'(cfg_i.num_strings);
    end
    if (cfg_i.num_languages == '0) begin
      nl_w = NLANG_W'(1);
    end else if (32'(cfg_i.num_languages) > 32'(MAX_LANGS)) begin
      nl_w = NLANG_W'(MAX_LANGS);
    end else begin
      nl_w = cfg_i.num_languages;
    end
  end

  assign mid0_w  = (SW'(n_w) - SW'(1)) >> 1;
  assign mid_e   = SW'(mid_q);
  assign first_e = SW'(first_q);
  assign end_e   = SW'(end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    first_q <= first_d;
    end_q   <= end_d;
    mid_q   <= mid_d;
    oidx_q  <= oidx_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d       = state_q;
    key_d         = key_q;
    first_d       = first_q;
    end_d         = end_q;
    mid_d         = mid_q;
    oidx_d        = oidx_q;
    res_d         = res_q;
    key_rd_en_o   = 1'b0;
    key_rd_addr_o = mid_q;
    off_rd_en_o   = 1'b0;
    off_rd_addr_o = OW'(oidx_q);
    res_valid_o   = 1'b0;
    next_mid_w    = '0;
    cont_w        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          first_d = '0;
          end_d   = n_w;
          if (n_w != '0) begin
            key_rd_en_o   = 1'b1;
            key_rd_addr_o = KW'(mid0_w);
            mid_d         = KW'(mid0_w);
            state_d       = ST_PROBE;
          end else begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        end
      end

      // The probed key is on the read port; the next probe is issued in
      // the same cycle.
      ST_PROBE: begin
        if (key_rd_data_i == key_q) begin
          state_d = ST_MUL;
        end else begin
          if (key_rd_data_i < key_q) begin
            first_d    = BW'(mid_e + SW'(1));
            cont_w     = (mid_e + SW'(1)) < end_e;
            next_mid_w = (mid_e + end_e) >> 1;
          end else begin
            end_d      = BW'(mid_q);
            cont_w     = first_e < mid_e;
            next_mid_w = (first_e + mid_e - SW'(1)) >> 1;
          end
          if (cont_w) begin
            key_rd_en_o   = 1'b1;
            key_rd_addr_o = KW'(next_mid_w);
            mid_d         = KW'(next_mid_w);
          end else begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        end
      end

      ST_MUL: begin
        oidx_d  = OIW'(mid_q) * OIW'(nl_w) + OIW'(cfg_i.language_slot);
        state_d = ST_REDUCE;
      end

      // Wrap the offset index into the table; one subtraction per cycle.
      ST_REDUCE: begin
        if (32'(oidx_q) >= 32'(DEPTH)) begin
          oidx_d = oidx_q - OIW'(DEPTH);
        end else begin
          off_rd_en_o = 1'b1;
          state_d     = ST_OFF_RD;
        end
      end

      ST_OFF_RD: begin
        res_d.found         = 1'b1;
        res_d.string_offset = off_rd_data_i;
        res_d.key_position  = POS_W'(mid_q);
        state_d             = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);
  assign res_o  = res_q;

endmodule

>>> rtl/skl_checker.sv
// Port-level checker for the sorted key table lookup, bound to the top level.
module skl_checker import skl_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [ACTION_W-1:0]   s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [M_TDATA_W-1:0]  m_axis_tdata,
  input logic                  m_axis_tuser
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A lookup occupies the sequencer, so no request is taken right after it.
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOOKUP) |=> !s_axis_tready)
    else $error("request taken while a lookup is in progress");

  // Writes and unused actions leave the block ready.
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_LOOKUP) |=> s_axis_tready)
    else $error("block not ready after a write or unused request");

  // A miss returns zero offset and zero position.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result carries nonzero data");

endmodule

bind sorted_key_table_lookup_top skl_checker u_skl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> dv/tb_top.sv
// Self-checking testbench of the sorted key table lookup: directed table, then random phases.
module tb_top import skl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_DEPTH   = 1024;
  localparam int unsigned LANG_MAX    = 8;
  localparam int unsigned OFF_DEPTH   = KEY_DEPTH * LANG_MAX;
  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYC  = 24;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    action_e      act;
    logic [12:0]  idx;
    logic [63:0]  key;
    logic [31:0]  off;
    logic [1:0]   cfg_reg;
    logic [31:0]  cfg_val;
    bit           typed;
    res_t         want;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the block: tables, what has been written, and the registers.
  bit [63:0]   key_mem [KEY_DEPTH];
  bit [31:0]   off_mem [OFF_DEPTH];
  bit          key_written [KEY_DEPTH];
  bit          off_written [OFF_DEPTH];
  cfg_t        cfg_now = '{num_strings: 11'd0, num_languages: 4'd1, language_slot: 3'd0};

  res_t        due_results [$];
  int unsigned mismatches = 0;
  int unsigned stall_cnt = 0;
  bit          calm = 1'b0;

  sorted_key_table_lookup_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Binary search over the shadow tables. Returns 0 if a probe would touch a
  // key entry that was never written.
  function automatic bit search_table(input logic [63:0] k, output res_t r,
                                      output int unsigned oi);
    int unsigned n;
    int unsigned nl;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit clean;
    n = cfg_now.num_strings;
    nl = cfg_now.num_languages;
    if (n > KEY_DEPTH) n = KEY_DEPTH;
    if (nl == 0) nl = 1;
    if (nl > LANG_MAX) nl = LANG_MAX;
    lo = 0;
    hi = n;
    clean = 1'b1;
    r = '0;
    oi = 0;
    while (lo < hi) begin
      mid = (lo + hi - 1) / 2;
      if (!key_written[mid]) clean = 1'b0;
      if (key_mem[mid] < k) begin
        lo = mid + 1;
      end else if (key_mem[mid] == k) begin
        oi = (mid * nl + cfg_now.language_slot) % OFF_DEPTH;
        r.found = 1'b1;
        r.string_offset = off_mem[oi];
        r.key_position = 10'(mid);
        break;
      end else begin
        hi = mid;
      end
    end
    return clean;
  endfunction

  // Offers one request, idling at random first, and records it once accepted.
  task automatic push_request(input action_e act, input logic [12:0] idx,
                              input logic [63:0] key, input logic [31:0] off,
                              input bit typed = 1'b0, input res_t want = '0);
    res_t r;
    int unsigned oi;
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {3'b000, off, key, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (act)
      ACT_WR_KEY: begin
        if (idx < KEY_DEPTH) begin
          key_mem[idx[9:0]] = key;
          key_written[idx[9:0]] = 1'b1;
        end
      end
      ACT_WR_OFF: begin
        off_mem[idx] = off;
        off_written[idx] = 1'b1;
      end
      ACT_LOOKUP: begin
        void'(search_table(key, r, oi));
        due_results.push_back(typed ? want : r);
      end
      default: ;
    endcase
  endtask

  // Waits until every expected result has come and the block has gone quiet.
  task automatic drain();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Register write followed by a back-to-back read of the same register.
  task automatic reg_write(input logic [1:0] sel, input logic [31:0] val);
    logic [31:0] want;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (sel)
      REG_NUM_STRINGS:   cfg_now.num_strings = val[NSTR_W-1:0];
      REG_NUM_LANGUAGES: cfg_now.num_languages = val[NLANG_W-1:0];
      REG_LANGUAGE_SLOT: cfg_now.language_slot = val[SLOT_W-1:0];
      default: ;
    endcase
    case (sel)
      REG_NUM_STRINGS:   want = {21'd0, cfg_now.num_strings};
      REG_NUM_LANGUAGES: want = {28'd0, cfg_now.num_languages};
      default:           want = {29'd0, cfg_now.language_slot};
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      mismatches++;
      $display("%0t: register %0d read back expected %h actual %h", $time, sel, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stalls, and each result checked against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result expected none actual found=%b offset=%h pos=%0d",
                 $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[41:32]);
      end else begin
        want = due_results.pop_front();
        if (m_axis_tuser !== want.found) begin
          mismatches++;
          $display("%0t: found expected %b actual %b", $time, want.found, m_axis_tuser);
        end
        if (m_axis_tdata[31:0] !== want.string_offset) begin
          mismatches++;
          $display("%0t: string_offset expected %h actual %h", $time,
                   want.string_offset, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[41:32] !== want.key_position) begin
          mismatches++;
          $display("%0t: key_position expected %0d actual %0d", $time,
                   want.key_position, m_axis_tdata[41:32]);
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 17);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : main
    row_t            plan [$];
    res_t            r;
    int unsigned     oi;
    int unsigned     rand_items;
    int unsigned     phase;
    int unsigned     n_cfg;
    int unsigned     neff;
    int unsigned     ops;
    int unsigned     pos;
    int unsigned     pick;
    longint unsigned stride;
    logic [63:0]     k;
    logic [63:0]     prev;

    // Directed requests. Typed expectations cover the empty table, a key below
    // every entry, plain hits and misses, and an unsorted table where the probe
    // order hides a present key.
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: 64'h0, typed: 1'b1, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, idx: 13'h1FFF, key: '1, off: '1,
                     typed: 1'b1, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_KEY, idx: 13'd0, key: 64'h10, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_KEY, idx: 13'd1, key: 64'h20, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_KEY, idx: 13'd2, key: '1, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_KEY, idx: 13'd1023, key: 64'h0, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_KEY, idx: 13'h1FFF, key: 64'h5, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_OFF, idx: 13'd0, off: 32'hDEAD_BEEF,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_OFF, idx: 13'd2, off: 32'h1234_5678,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_OFF, idx: 13'h1FFF, off: '1, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_NOP, idx: 13'h1FFF, key: '1, off: '1,
                     default: '0});
    plan.push_back('{kind: ROW_CFG, act: ACT_NOP, cfg_reg: REG_NUM_STRINGS, cfg_val: 32'd3,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: 64'h10, typed: 1'b1,
                     want: '{1'b1, 32'hDEAD_BEEF, 10'd0}, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: 64'h5, typed: 1'b1, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: '1, typed: 1'b1,
                     want: '{1'b1, 32'h1234_5678, 10'd2}, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: 64'h15, typed: 1'b1, default: '0});
    plan.push_back('{kind: ROW_CFG, act: ACT_NOP, cfg_reg: REG_NUM_LANGUAGES, cfg_val: 32'd0,
                     default: '0});
    plan.push_back('{kind: ROW_CFG, act: ACT_NOP, cfg_reg: REG_LANGUAGE_SLOT, cfg_val: 32'd1,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: 64'h20, default: '0});
    plan.push_back('{kind: ROW_CFG, act: ACT_NOP, cfg_reg: REG_NUM_LANGUAGES, cfg_val: 32'd15,
                     default: '0});
    plan.push_back('{kind: ROW_CFG, act: ACT_NOP, cfg_reg: REG_LANGUAGE_SLOT, cfg_val: 32'd7,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_OFF, idx: 13'd23, off: 32'hA5A5_5A5A,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: '1, default: '0});
    plan.push_back('{kind: ROW_CFG, act: ACT_NOP, cfg_reg: REG_NUM_LANGUAGES, cfg_val: 32'd1,
                     default: '0});
    plan.push_back('{kind: ROW_CFG, act: ACT_NOP, cfg_reg: REG_LANGUAGE_SLOT, cfg_val: 32'd0,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_KEY, idx: 13'd1, key: 64'h5, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_WR_OFF, idx: 13'd1, off: 32'h0000_0001,
                     default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: 64'h5, typed: 1'b1,
                     want: '{1'b1, 32'h0000_0001, 10'd1}, default: '0});
    plan.push_back('{kind: ROW_ITEM, act: ACT_LOOKUP, key: 64'h10, typed: 1'b1, default: '0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        s_axis_tvalid <= 1'b0;
        drain();
        reg_write(plan[i].cfg_reg, plan[i].cfg_val);
      end else begin
        push_request(plan[i].act, plan[i].idx, plan[i].key, plan[i].off,
                     plan[i].typed, plan[i].want);
      end
    end

    // Random phases: each sets the registers, loads a sorted table, then runs
    // mostly lookups with writes, ignored writes and unused actions mixed in.
    // The full table is built once; the phase after it reuses it with an
    // oversized entry count.
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      case (phase)
        0:       n_cfg = 0;
        3:       n_cfg = KEY_DEPTH;
        4:       n_cfg = 2047;
        default: n_cfg = $urandom_range(40, 1);
      endcase
      neff = (n_cfg > KEY_DEPTH) ? KEY_DEPTH : n_cfg;
      s_axis_tvalid <= 1'b0;
      drain();
      calm = (phase == 1);
      reg_write(REG_NUM_STRINGS, n_cfg);
      reg_write(REG_NUM_LANGUAGES, ($urandom_range(3) == 0) ? $urandom_range(15)
                                                            : $urandom_range(8, 1));
      reg_write(REG_LANGUAGE_SLOT, $urandom_range(7));

      if (phase != 4) begin
        stride = 64'hFFFF_FFFF_FFFF_FFFF / (longint'(neff) + 1);
        prev = '0;
        for (int i = 0; i < neff; i++) begin
          if (i > 0 && $urandom_range(15) == 0)
            k = prev;
          else
            k = longint'(i) * stride + ({$urandom, $urandom} % stride);
          if (i == 0 && $urandom_range(3) == 0) k = '0;
          if (i == neff - 1 && $urandom_range(3) == 0) k = '1;
          push_request(ACT_WR_KEY, 13'(i), k, $urandom);
          prev = k;
          rand_items++;
        end
      end

      ops = $urandom_range(60, 30);
      for (int j = 0; j < ops; j++) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          pos = (neff > 0) ? $urandom_range(neff - 1) : 0;
          case ($urandom_range(9))
            0, 1, 2, 3, 4: k = key_mem[pos];
            5:             k = key_mem[pos] + 64'd1;
            6:             k = key_mem[pos] - 64'd1;
            7:             k = {$urandom, $urandom};
            8:             k = '0;
            default:       k = '1;
          endcase
          if (search_table(k, r, oi)) begin
            // A hit must find its offset entry already written.
            if (r.found && !off_written[oi]) begin
              push_request(ACT_WR_OFF, 13'(oi), {$urandom, $urandom}, $urandom);
              rand_items++;
            end
            push_request(ACT_LOOKUP, 13'($urandom_range(8191)), k, $urandom);
            rand_items++;
          end
        end else if (pick < 77) begin
          push_request(ACT_WR_OFF, 13'($urandom_range(8191)), {$urandom, $urandom}, $urandom);
          rand_items++;
        end else if (pick < 85) begin
          push_request(ACT_WR_KEY, 13'($urandom_range(8191, KEY_DEPTH)),
                       {$urandom, $urandom}, $urandom);
        end else if (pick < 92) begin
          // Lands anywhere in the key table, so the order may break.
          push_request(ACT_WR_KEY, 13'($urandom_range(KEY_DEPTH - 1)),
                       {$urandom, $urandom}, $urandom);
          rand_items++;
        end else begin
          push_request(ACT_NOP, 13'($urandom_range(8191)), {$urandom, $urandom}, $urandom);
        end
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
